// ===== sv/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, divider latency and register indexes of the ray/box slab test.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

   // Width of Q-format coordinates, bounds and parameters
   localparam int DATA_W = 32;
   // Width of the unsigned epsilon and ray tmax fields
   localparam int UDATA_W = 31;
   // Quotient bits developed by the divider, one per stage
   localparam int QUO_W = 32;
   // Divider latency: load stage, one stage per quotient bit, saturate stage
   localparam int DIV_LAT = QUO_W + 2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_EPS       = 3'd6;

   localparam logic [UDATA_W-1:0] EPS_RESET = 31'd16;

   // Saturation limits
   localparam logic signed [DATA_W-1:0] T_MAX_POS = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] T_MAX_NEG = 32'sh8000_0000;

   typedef logic signed [DATA_W-1:0] coord_type;

endpackage

`default_nettype wire

// ===== sv/rbsi_req_if.sv =====
// ----------------------------------------------------------------------------
// rbsi_req_if
// Ray transaction channel: origin, direction and maximum parameter.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbsi_req_if;
   import rbsi_pkg::*;

   logic                valid;
   logic                ready;
   coord_type           origin_x;
   coord_type           origin_y;
   coord_type           origin_z;
   coord_type           dir_x;
   coord_type           dir_y;
   coord_type           dir_z;
   logic [UDATA_W-1:0]  ray_tmax;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   ray_tmax, input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   ray_tmax, output ready);
endinterface

`default_nettype wire

// ===== sv/rbsi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rbsi_rsp_if
// Result transaction channel: hit flag and final parameter interval.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbsi_rsp_if;
   import rbsi_pkg::*;

   logic       valid;
   logic       ready;
   logic       hit;
   coord_type  t_near;
   coord_type  t_far;

   modport source (output valid, hit, t_near, t_far, input ready);
   modport sink   (input valid, hit, t_near, t_far, output ready);
endinterface

`default_nettype wire

// ===== sv/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Slab-method ray versus axis-aligned box test in signed fixed point.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        contents
//  req_bus   in    valid/ready      origin xyz, dir xyz, ray_tmax
//  rsp_bus   out   valid/ready      hit, t_near, t_far
//  csr_*     in    write enable     box bounds, parallel epsilon
//
//  One ray enters per cycle unless the pipeline holds. The datapath
//  holds six pipelined divider lanes, one quotient bit per stage. The whole
//  pipeline advances while the output stage is empty or taken; otherwise
//  it holds. Reset clears the valid bits and loads the register reset
//  values.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect import rbsi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rbsi_req_if.sink                   req_bus,
   rbsi_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]     csr_wdata
);

   localparam int NUM_W = DATA_W + 1 + FRAC_BITS;

   // Configuration registers
   coord_type          box_min_ff [0:2];
   coord_type          box_max_ff [0:2];
   logic [UDATA_W-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
         eps_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_BOX_MIN_X: box_min_ff[0] <= csr_wdata;
            REG_BOX_MIN_Y: box_min_ff[1] <= csr_wdata;
            REG_BOX_MIN_Z: box_min_ff[2] <= csr_wdata;
            REG_BOX_MAX_X: box_max_ff[0] <= csr_wdata;
            REG_BOX_MAX_Y: box_max_ff[1] <= csr_wdata;
            REG_BOX_MAX_Z: box_max_ff[2] <= csr_wdata;
            REG_EPS:       eps_ff <= csr_wdata[UDATA_W-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: output register free or being taken
   logic out_valid_ff;
   logic adv;
   assign adv = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   coord_type org [0:2];
   coord_type dir [0:2];
   assign org[0] = req_bus.origin_x;
   assign org[1] = req_bus.origin_y;
   assign org[2] = req_bus.origin_z;
   assign dir[0] = req_bus.dir_x;
   assign dir[1] = req_bus.dir_y;
   assign dir[2] = req_bus.dir_z;

   // Front stage: slab distances, magnitudes and parallel checks
   logic [NUM_W-1:0]  num_lo_ff [0:2];
   logic [NUM_W-1:0]  num_hi_ff [0:2];
   logic [QUO_W-1:0]  den_ff    [0:2];
   logic              neg_lo_ff [0:2];
   logic              neg_hi_ff [0:2];
   logic [2:0]        par_in, pmiss_in;
   coord_type         t_a [0:2];
   coord_type         t_b [0:2];

   for (genvar g = 0; g < 3; g++) begin : g_axis
      logic signed [DATA_W:0] d_lo, d_hi;
      logic [DATA_W:0]        m_lo, m_hi;
      logic [QUO_W-1:0]       mag;

      always_comb begin
         d_lo = {box_min_ff[g][DATA_W-1], box_min_ff[g]} - {org[g][DATA_W-1], org[g]};
         d_hi = {box_max_ff[g][DATA_W-1], box_max_ff[g]} - {org[g][DATA_W-1], org[g]};
         m_lo = d_lo[DATA_W] ? -d_lo : d_lo;
         m_hi = d_hi[DATA_W] ? -d_hi : d_hi;
         mag  = dir[g][DATA_W-1] ? -dir[g] : dir[g];
         par_in[g]   = (dir[g] == '0) || (mag < {1'b0, eps_ff});
         pmiss_in[g] = (org[g] < box_min_ff[g]) || (org[g] > box_max_ff[g]);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num_lo_ff[g] <= {m_lo, {FRAC_BITS{1'b0}}};
            num_hi_ff[g] <= {m_hi, {FRAC_BITS{1'b0}}};
            den_ff[g]    <= mag;
            neg_lo_ff[g] <= d_lo[DATA_W] ^ dir[g][DATA_W-1];
            neg_hi_ff[g] <= d_hi[DATA_W] ^ dir[g][DATA_W-1];
         end
      end

      rbsi_div_lane #(.NUM_W(NUM_W)) u_div_lo (
         .clock (clock),
         .adv   (adv),
         .num   (num_lo_ff[g]),
         .den   (den_ff[g]),
         .neg   (neg_lo_ff[g]),
         .quo   (t_a[g])
      );

      rbsi_div_lane #(.NUM_W(NUM_W)) u_div_hi (
         .clock (clock),
         .adv   (adv),
         .num   (num_hi_ff[g]),
         .den   (den_ff[g]),
         .neg   (neg_hi_ff[g]),
         .quo   (t_b[g])
      );
   end

   // Sideband delay line matching the dividers
   logic               vld_ff   [0:DIV_LAT];
   logic [2:0]         par_ff   [0:DIV_LAT];
   logic               pmiss_ff [0:DIV_LAT];
   logic [UDATA_W-1:0] tmax_ff  [0:DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_bus.valid;
         for (int i = 1; i <= DIV_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         par_ff[0]   <= par_in;
         pmiss_ff[0] <= |(par_in & pmiss_in);
         tmax_ff[0]  <= req_bus.ray_tmax;
         for (int i = 1; i <= DIV_LAT; i++) begin
            par_ff[i]   <= par_ff[i-1];
            pmiss_ff[i] <= pmiss_ff[i-1];
            tmax_ff[i]  <= tmax_ff[i-1];
         end
      end
   end

   // Order stage: order each slab pair so near <= far; parallel axes become neutral
   coord_type tn_in [0:2];
   coord_type tf_in [0:2];
   coord_type tn_ff [0:2];
   coord_type tf_ff [0:2];
   coord_type tmax_s;
   logic      sw_vld_ff, sw_pmiss_ff;
   coord_type sw_tmax_ff;

   assign tmax_s = {1'b0, tmax_ff[DIV_LAT]};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (par_ff[DIV_LAT][i]) begin
            tn_in[i] = '0;
            tf_in[i] = tmax_s;
         end else if (t_a[i] > t_b[i]) begin
            tn_in[i] = t_b[i];
            tf_in[i] = t_a[i];
         end else begin
            tn_in[i] = t_a[i];
            tf_in[i] = t_b[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_vld_ff <= 1'b0;
      end else if (adv) begin
         sw_vld_ff <= vld_ff[DIV_LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            tn_ff[i] <= tn_in[i];
            tf_ff[i] <= tf_in[i];
         end
         sw_pmiss_ff <= pmiss_ff[DIV_LAT];
         sw_tmax_ff  <= tmax_s;
      end
   end

   // Reduce stage: interval overlap over all three axes
   coord_type n01, n2, f01, f2, t0_in, t1_in;
   coord_type t0_ff, t1_ff;
   logic      rd_vld_ff, rd_pmiss_ff;

   always_comb begin
      n01   = (tn_ff[0] > tn_ff[1]) ? tn_ff[0] : tn_ff[1];
      n2    = (tn_ff[2] > 0) ? tn_ff[2] : '0;
      t0_in = (n01 > n2) ? n01 : n2;
      f01   = (tf_ff[0] < tf_ff[1]) ? tf_ff[0] : tf_ff[1];
      f2    = (tf_ff[2] < sw_tmax_ff) ? tf_ff[2] : sw_tmax_ff;
      t1_in = (f01 < f2) ? f01 : f2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (adv) begin
         rd_vld_ff <= sw_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff       <= t0_in;
         t1_ff       <= t1_in;
         rd_pmiss_ff <= sw_pmiss_ff;
      end
   end

   // Output stage: final hit decision
   logic      hit_in, hit_ff;
   coord_type t_near_ff, t_far_ff;

   assign hit_in = !rd_pmiss_ff && !(t0_ff > t1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff    <= hit_in;
         t_near_ff <= hit_in ? t0_ff : '0;
         t_far_ff  <= hit_in ? t1_ff : '0;
      end
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.hit    = hit_ff;
   assign rsp_bus.t_near = t_near_ff;
   assign rsp_bus.t_far  = t_far_ff;

endmodule

`default_nettype wire

// ===== sv/rbsi_div_lane.sv =====
// ----------------------------------------------------------------------------
// rbsi_div_lane
// Pipelined restoring divider, one quotient bit per stage, with sign
// restore and saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_div_lane import rbsi_pkg::*; #(
   parameter int NUM_W = 49
) (
   input  wire logic              clock,
   input  wire logic              adv,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [QUO_W-1:0]  den,
   input  wire logic              neg,
   output logic signed [DATA_W-1:0] quo
);

   localparam int HI_W = NUM_W - QUO_W;

   logic [QUO_W-1:0] rem_ff [0:QUO_W];
   logic [QUO_W-1:0] low_ff [0:QUO_W];
   logic [QUO_W-1:0] qb_ff  [0:QUO_W];
   logic [QUO_W-1:0] den_ff [0:QUO_W];
   logic             neg_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];
   logic [QUO_W-1:0] hi_ext;
   logic signed [DATA_W-1:0] quo_in, quo_ff;

   // Load: upper numerator bits seed the remainder; quotient overflow if
   // they already reach the divisor
   assign hi_ext = {{(QUO_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= hi_ext;
         low_ff[0] <= num[QUO_W-1:0];
         qb_ff[0]  <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         ovf_ff[0] <= (hi_ext >= den);
      end
   end

   // One quotient bit per stage
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [QUO_W:0]   trial;
      logic [QUO_W:0]   diff;
      logic             ge;
      logic [QUO_W-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k], low_ff[k][QUO_W-1]};
         diff   = trial - {1'b0, den_ff[k]};
         ge     = (trial >= {1'b0, den_ff[k]});
         rem_in = ge ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= rem_in;
            low_ff[k+1] <= {low_ff[k][QUO_W-2:0], 1'b0};
            qb_ff[k+1]  <= {qb_ff[k][QUO_W-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   // Sign restore and saturation
   always_comb begin
      if (neg_ff[QUO_W]) begin
         if (ovf_ff[QUO_W] || (qb_ff[QUO_W] > 32'h8000_0000)) begin
            quo_in = T_MAX_NEG;
         end else begin
            quo_in = -$signed(qb_ff[QUO_W]);
         end
      end else begin
         if (ovf_ff[QUO_W] || qb_ff[QUO_W][QUO_W-1]) begin
            quo_in = T_MAX_POS;
         end else begin
            quo_in = $signed(qb_ff[QUO_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire
